// ===== hdl/vlpd_pkg.sv =====
package vlpd_pkg;

    // field widths
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 21;
    localparam int ID_W     = 32;
    localparam int ACC_W    = 32;
    localparam int GROUP_W  = 3;
    localparam int ROLE_W   = 2;
    localparam int ERR_W    = 2;
    localparam int PHASE_W  = 2;
    localparam int M_DATA_W = 64;

    // varint limits
    localparam logic [GROUP_W-1:0] MAX_GROUPS = 3'd5;
    localparam logic [LEN_W-1:0]   LEN_RESET  = 21'h1FFFFF;

    // phase codes
    localparam logic [PHASE_W-1:0] PH_PREFIX  = 2'd0;
    localparam logic [PHASE_W-1:0] PH_ID      = 2'd1;
    localparam logic [PHASE_W-1:0] PH_PAYLOAD = 2'd2;

    // byte role codes
    localparam logic [ROLE_W-1:0] ROLE_PREFIX  = 2'd0;
    localparam logic [ROLE_W-1:0] ROLE_ID      = 2'd1;
    localparam logic [ROLE_W-1:0] ROLE_PAYLOAD = 2'd2;

    // error codes
    localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
    localparam logic [ERR_W-1:0] ERR_OVERLONG = 2'd1;
    localparam logic [ERR_W-1:0] ERR_TOO_LONG = 2'd2;
    localparam logic [ERR_W-1:0] ERR_FRAMING  = 2'd3;

    // one result item
    typedef struct packed {
        logic [ERR_W-1:0]  error_code;
        logic              frame_end;
        logic              id_ready;
        logic [ID_W-1:0]   packet_id;
        logic [LEN_W-1:0]  frame_length;
        logic [ROLE_W-1:0] byte_role;
        logic [BYTE_W-1:0] data_byte;
    } vlpd_result_t;

endpackage

// ===== hdl/vlpd_step.sv =====
module vlpd_step (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       step_en,
    input  logic [vlpd_pkg::BYTE_W-1:0] rx_byte,
    input  logic [vlpd_pkg::LEN_W-1:0]  max_len,
    output vlpd_pkg::vlpd_result_t     result
);
    import vlpd_pkg::*;

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [GROUP_W-1:0] group_reg, group_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [LEN_W-1:0]   left_reg, left_next;
    logic [ID_W-1:0]    id_reg, id_next;

    logic               more;
    logic [ACC_W-1:0]   part;
    logic [ACC_W-1:0]   acc_new;
    logic [GROUP_W-1:0] group_inc;
    logic               group_full;
    logic [LEN_W-1:0]   left_dec;

    // place the 7 data bits by group index (only the low 4 bits in group 4), index taken modulo five
    always_comb begin
        case (group_reg) inside
            3'd0, 3'd5: part = {25'd0, rx_byte[6:0]};
            3'd1, 3'd6: part = {18'd0, rx_byte[6:0], 7'd0};
            3'd2, 3'd7: part = {11'd0, rx_byte[6:0], 14'd0};
            3'd3:       part = {4'd0, rx_byte[6:0], 21'd0};
            default:    part = {rx_byte[3:0], 28'd0};
        endcase
    end

    assign more       = rx_byte[7];
    assign acc_new    = acc_reg | part;
    assign group_inc  = group_reg + 3'd1;
    assign group_full = (group_inc >= MAX_GROUPS);
    assign left_dec   = left_reg - 21'd1;

    // per-byte decode and next state
    always_comb begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        group_next = group_reg;
        len_next   = len_reg;
        left_next  = left_reg;
        id_next    = id_reg;

        result              = '0;
        result.data_byte    = rx_byte;

        unique case (phase_reg)
            PH_PREFIX: begin
                result.byte_role = ROLE_PREFIX;
                acc_next   = acc_new;
                group_next = group_inc;
                if (more) begin
                    if (group_full) begin
                        result.error_code = ERR_OVERLONG;
                        acc_next   = '0;
                        group_next = '0;
                    end
                end else if (acc_new > {11'd0, max_len}) begin
                    result.error_code = ERR_TOO_LONG;
                    acc_next   = '0;
                    group_next = '0;
                end else if (acc_new == '0) begin
                    result.error_code = ERR_FRAMING;
                    acc_next   = '0;
                    group_next = '0;
                end else begin
                    len_next            = acc_new[LEN_W-1:0];
                    left_next           = acc_new[LEN_W-1:0];
                    result.frame_length = acc_new[LEN_W-1:0];
                    phase_next          = PH_ID;
                    acc_next            = '0;
                    group_next          = '0;
                end
            end
            PH_ID: begin
                result.byte_role    = ROLE_ID;
                result.frame_length = len_reg;
                acc_next   = acc_new;
                group_next = group_inc;
                left_next  = left_dec;
                if (more) begin
                    if (group_full) begin
                        result.error_code   = ERR_OVERLONG;
                        result.frame_length = '0;
                        phase_next = PH_PREFIX;
                        acc_next   = '0;
                        group_next = '0;
                    end else if (left_dec == '0) begin
                        result.error_code   = ERR_FRAMING;
                        result.frame_length = '0;
                        phase_next = PH_PREFIX;
                        acc_next   = '0;
                        group_next = '0;
                    end
                end else begin
                    id_next          = acc_new;
                    result.packet_id = acc_new;
                    result.id_ready  = 1'b1;
                    if (left_dec == '0) begin
                        result.frame_end = 1'b1;
                        phase_next = PH_PREFIX;
                        acc_next   = '0;
                        group_next = '0;
                    end else begin
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            default: begin
                result.byte_role    = ROLE_PAYLOAD;
                result.frame_length = len_reg;
                result.packet_id    = id_reg;
                result.id_ready     = 1'b1;
                left_next = left_dec;
                if (left_dec == '0) begin
                    result.frame_end = 1'b1;
                    phase_next = PH_PREFIX;
                    acc_next   = '0;
                    group_next = '0;
                end
            end
        endcase
    end

    // decoder state, advanced once per consumed byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_PREFIX;
            acc_reg   <= '0;
            group_reg <= '0;
            len_reg   <= '0;
            left_reg  <= '0;
            id_reg    <= '0;
        end else if (step_en) begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            group_reg <= group_next;
            len_reg   <= len_next;
            left_reg  <= left_next;
            id_reg    <= id_next;
        end
    end

endmodule

// ===== hdl/varint_length_prefixed_deframer.sv =====
// Varint length-prefixed deframer. Each received byte goes in on the s_ stream
// and comes back out on the m_ stream tagged with its role (prefix, packet id or
// payload), the decoded frame length, the packet id once complete, an error code,
// and tlast on the last byte of a good frame. It sustains one byte per clock
// while m_tready is high. A byte is held in the input register and is decoded
// into the result register when it advances, and its result is presented from
// the result register until it is taken. A result that is held back by m_tready
// holds the input register, and the input stalls once that is full. The rate is
// set by the decoder state loop, which updates once per byte. After any error the
// next byte starts a new length prefix. The user must write max_frame_length
// through cfg_wr_en/cfg_wr_data only while the stream is idle; the block does
// not enforce this. It resets to the largest 21-bit value.
module varint_length_prefixed_deframer (
    input  logic                          aclk,
    input  logic                          aresetn,
    // config
    input  logic                          cfg_wr_en,
    input  logic [vlpd_pkg::LEN_W-1:0]    cfg_wr_data,   // max_frame_length
    // byte input
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [vlpd_pkg::BYTE_W-1:0]   s_tdata,       // rx_byte
    // result output
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // data_byte[7:0], frame_length[28:8], packet_id[60:29], id_ready[61],
    // error_code[63:62]
    output logic [vlpd_pkg::M_DATA_W-1:0] m_tdata,
    output logic [vlpd_pkg::ROLE_W-1:0]   m_tuser,       // byte_role
    output logic                          m_tlast        // frame_end
);
    import vlpd_pkg::*;

    logic               in_valid_reg;
    logic [BYTE_W-1:0]  in_byte_reg;
    logic               out_valid_reg;
    vlpd_result_t       out_res_reg;
    logic [LEN_W-1:0]   max_len_reg;
    logic               advance;
    vlpd_result_t       step_res;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= LEN_RESET;
        end else if (cfg_wr_en) begin
            max_len_reg <= cfg_wr_data;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    vlpd_step u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .rx_byte (in_byte_reg),
        .max_len (max_len_reg),
        .result  (step_res)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= step_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_res_reg.error_code, out_res_reg.id_ready, out_res_reg.packet_id,
                       out_res_reg.frame_length, out_res_reg.data_byte};
    assign m_tuser  = out_res_reg.byte_role;
    assign m_tlast  = out_res_reg.frame_end;

endmodule

// ===== hdl/vlpd_checker.sv =====
module vlpd_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [vlpd_pkg::M_DATA_W-1:0] m_tdata,
    input logic [vlpd_pkg::ROLE_W-1:0]   m_tuser,
    input logic                          m_tlast
);
    import vlpd_pkg::*;

    // a good frame end carries a decoded id and no error
    a_end_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata[61] && (m_tdata[63:62] == ERR_NONE))
        else $error("frame end with error or without id");

    // payload bytes only follow a complete id
    a_payload_id: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ROLE_PAYLOAD) |-> m_tdata[61] && (m_tdata[63:62] == ERR_NONE))
        else $error("payload byte without id");

    // an error result carries no id
    a_err_no_id: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[63:62] != ERR_NONE) |-> !m_tdata[61] && (m_tdata[60:29] == '0))
        else $error("error result shows an id");

    // a stalled result request holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result changed");

endmodule

bind varint_length_prefixed_deframer vlpd_checker u_vlpd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
